@@ rtl/bqlp_pkg.sv @@
// Package for the biquad low-pass stereo ring writer: widths, payload structs,
// register indexes and the coefficient bundle. No dependencies.
`default_nettype none

package bqlp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int HIST_W     = 32;
  localparam int RING_W     = 16;
  localparam int CFG_W      = 18;
  localparam int CFG_ADDR_W = 3;

  // product and accumulator widths
  localparam int FF_PROD_W = COEF_W + SAMPLE_W;  // b * x
  localparam int FB_PROD_W = COEF_W + HIST_W;    // a * y
  localparam int ACC_W     = FB_PROD_W + 3;      // five-term sum, exact
  localparam int FRAC_DROP = 16;                 // Q.31 -> Q.15
  localparam int RND_W     = ACC_W - FRAC_DROP;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd32768);
  localparam logic signed [RND_W-1:0] HIST_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] HIST_MIN = RND_W'(-64'sd2147483648);
  localparam logic signed [HIST_W-1:0] PCM_MAX = HIST_W'(32'sd32767);
  localparam logic signed [HIST_W-1:0] PCM_MIN = HIST_W'(-32'sd32768);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FEED0 = 3'd0,
    REG_FEED1 = 3'd1,
    REG_FEED2 = 3'd2,
    REG_BACK1 = 3'd3,
    REG_BACK2 = 3'd4,
    REG_RING  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic [RING_W-1:0]          ring_index;
    logic                       channel;
    logic                       clipped;
    logic                       last;
    logic                       block_done;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] feed0;
    logic signed [COEF_W-1:0] feed1;
    logic signed [COEF_W-1:0] feed2;
    logic signed [COEF_W-1:0] back1;
    logic signed [COEF_W-1:0] back2;
    logic [RING_W-1:0]        ring_size;
  } coef_t;

  // head of the input queue as seen by the filter engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

@@ rtl/bqlp_front.sv @@
// Input side: a two-entry queue of accepted samples ahead of the filter engine.
// Depends on bqlp_pkg.
`default_nettype none

module bqlp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bqlp_pkg::in_item_t item,
  output logic                    full,
  output bqlp_pkg::q_head_t       head,
  input  wire logic               pop
);
  import bqlp_pkg::*;

  in_item_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic                    wr_en, rd_en;

  assign full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bqlp_back.sv @@
// Filter engine and result stage: product register, accumulate/round/saturate,
// filter history, left/right emission and ring position. Depends on bqlp_pkg.
`default_nettype none

module bqlp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bqlp_pkg::coef_t    coef,
  input  wire bqlp_pkg::q_head_t  head,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output bqlp_pkg::out_item_t     out_item
);
  import bqlp_pkg::*;

  // product stage
  logic                        s1_valid_r;
  logic signed [FF_PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [FB_PROD_W-1:0] p3_r, p4_r;
  logic                        bend1_r;

  // history
  logic signed [SAMPLE_W-1:0]  x1_r, x2_r;
  logic signed [HIST_W-1:0]    y1_r, y2_r;

  // result stage
  logic                        s2_valid_r;
  logic                        side_r;
  logic signed [SAMPLE_W-1:0]  pcm_r;
  logic                        clip_r;
  logic                        bend2_r;
  logic [RING_W-1:0]           wp_r;

  logic                        out_xfer, s2_free, s1_adv, s1_load;
  logic signed [ACC_W-1:0]     acc;
  logic signed [RND_W-1:0]     y_rnd;
  logic signed [HIST_W-1:0]    y_sat;
  logic signed [SAMPLE_W-1:0]  pcm_nxt;
  logic                        clip_nxt;
  logic [RING_W:0]             size_ext, nxt_ext;
  logic [RING_W-1:0]           slot, wp_nxt;

  assign out_empty = !s2_valid_r;
  assign out_xfer  = out_pop && s2_valid_r;
  assign s2_free   = !s2_valid_r || (side_r && out_xfer);
  assign s1_adv    = s1_valid_r && s2_free;
  // one sample in the product stage at a time: the next one needs this y
  assign s1_load   = !s1_valid_r && head.valid;
  assign q_pop     = s1_load;

  always_comb begin
    acc = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) - ACC_W'(p3_r) - ACC_W'(p4_r);
    acc = acc + RND_HALF;
    y_rnd = $signed(acc[ACC_W-1:FRAC_DROP]);
    if (y_rnd > HIST_MAX) begin
      y_sat = HIST_MAX[HIST_W-1:0];
    end else if (y_rnd < HIST_MIN) begin
      y_sat = HIST_MIN[HIST_W-1:0];
    end else begin
      y_sat = y_rnd[HIST_W-1:0];
    end
    clip_nxt = 1'b0;
    if (y_sat > PCM_MAX) begin
      pcm_nxt  = PCM_MAX[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else if (y_sat < PCM_MIN) begin
      pcm_nxt  = PCM_MIN[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else begin
      pcm_nxt = y_sat[SAMPLE_W-1:0];
    end
  end

  // ring slot: size zero means the full 16-bit range
  always_comb begin
    size_ext = (coef.ring_size == '0) ? {1'b1, {RING_W{1'b0}}} : {1'b0, coef.ring_size};
    slot     = ({1'b0, wp_r} < size_ext) ? wp_r : '0;
    nxt_ext  = {1'b0, slot} + (RING_W+1)'(1);
    wp_nxt   = (nxt_ext >= size_ext) ? '0 : nxt_ext[RING_W-1:0];
  end

  assign out_item.pcm        = pcm_r;
  assign out_item.ring_index = slot;
  assign out_item.channel    = side_r;
  assign out_item.clipped    = clip_r;
  assign out_item.last       = side_r;
  assign out_item.block_done = side_r && bend2_r;

  // payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      p0_r    <= FF_PROD_W'(coef.feed0) * FF_PROD_W'(head.item.sample);
      p1_r    <= FF_PROD_W'(coef.feed1) * FF_PROD_W'(x1_r);
      p2_r    <= FF_PROD_W'(coef.feed2) * FF_PROD_W'(x2_r);
      p3_r    <= FB_PROD_W'(coef.back1) * FB_PROD_W'(y1_r);
      p4_r    <= FB_PROD_W'(coef.back2) * FB_PROD_W'(y2_r);
      bend1_r <= head.item.block_end;
    end
    if (s1_adv) begin
      pcm_r   <= pcm_nxt;
      clip_r  <= clip_nxt;
      bend2_r <= bend1_r;
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      side_r     <= 1'b0;
      x1_r       <= '0;
      x2_r       <= '0;
      y1_r       <= '0;
      y2_r       <= '0;
      wp_r       <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        x1_r       <= head.item.sample;
        x2_r       <= x1_r;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        y1_r <= y_sat;
        y2_r <= y1_r;
      end
      if (out_xfer) begin
        wp_r <= wp_nxt;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
        side_r     <= 1'b0;
      end else if (out_xfer) begin
        if (side_r) begin
          s2_valid_r <= 1'b0;
          side_r     <= 1'b0;
        end else begin
          side_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/biquad_lowpass_stereo_ring_writer.sv @@
// Biquad low-pass, mono in, stereo ring-buffer writes out.
// Each accepted Q1.15 sample runs through a direct-form-I biquad with Q2.16
// coefficients (y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2), rounded half up to
// Q.15, held in history saturated to 32 bits, and transferred out twice as
// 16-bit PCM: left copy, then right copy, each with the ring slot it lands in.
// The ring position steps once per output transfer and wraps at ring_size
// (zero means 65536). The y1 feedback loop runs through the product register
// and the accumulate/round/saturate stage, so the next sample may enter the
// multipliers only after the previous one has moved on to the result stage.
// With an idle block, a sample passes the queue, the product register and the
// result register in turn on its way to the left copy. A two-entry input queue
// sits ahead of the engine, so samples keep being taken while results wait at
// the output. Depends on bqlp_pkg, bqlp_front and bqlp_back.
`default_nettype none

module biquad_lowpass_stereo_ring_writer (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_push,
  input  wire bqlp_pkg::in_item_t                   in_item,
  output logic                                      in_full,
  // result channel
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output bqlp_pkg::out_item_t                       out_item,
  // register writes
  input  wire logic                                 cfg_we,
  input  wire logic [bqlp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [bqlp_pkg::CFG_W-1:0]           cfg_wdata
);
  import bqlp_pkg::*;

  coef_t   coef_r;
  q_head_t head;
  logic    q_pop;

  // Register file: user writes only while idle (unenforced), so no shadowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.feed0     <= '0;
      coef_r.feed1     <= '0;
      coef_r.feed2     <= '0;
      coef_r.back1     <= '0;
      coef_r.back2     <= '0;
      coef_r.ring_size <= RING_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FEED0: coef_r.feed0     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_FEED1: coef_r.feed1     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_FEED2: coef_r.feed2     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_BACK1: coef_r.back1     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_BACK2: coef_r.back2     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_RING:  coef_r.ring_size <= cfg_wdata[RING_W-1:0];
        default:   ; // unused indexes are dropped
      endcase
    end
  end

  // front: input transfer and queueing
  bqlp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .item  (in_item),
    .full  (in_full),
    .head  (head),
    .pop   (q_pop)
  );

  // back: filter, saturation, left/right emission, ring slot
  bqlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .head      (head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // a left copy is always followed by its right copy, already waiting
  a_left_then_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.channel) |=> (!out_empty && out_item.channel))
    else $error("right copy missing after left transfer");

  // the slot handed out lies inside the ring
  a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && coef_r.ring_size != '0) |-> (out_item.ring_index < coef_r.ring_size))
    else $error("ring index beyond ring size");

  // the two copies of one sample carry the same PCM value and clip flag
  a_copies_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.channel) |=>
      (out_item.pcm == $past(out_item.pcm) && out_item.clipped == $past(out_item.clipped)))
    else $error("left and right copies differ");
`endif

endmodule

`default_nettype wire
